// ===== rtl/cpm_pkg.sv =====
// Shared types and constants for the capture period pulse meter.
package cpm_pkg;

  localparam int STAMP_W     = 16;
  localparam int FREQ_W      = 32;
  localparam int PULSE_W     = 19;
  localparam int DIV_CNT_W   = $clog2(FREQ_W);
  localparam int DIV_LAST    = FREQ_W - 1;

  localparam logic [FREQ_W-1:0] FREQ_NUM_RESET = 32'd1152000000;

  // pulse_ns = on_ticks * 125 / 18; the divide by 18 is a reciprocal multiply
  localparam int PULSE_MUL   = 125;
  localparam int PULSE_DIV   = 18;
  localparam int PROD_W      = STAMP_W + 7;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 24;
  localparam int MUL_W       = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd14913080;  // floor(2^28 / 18)

  typedef enum logic {
    REQ_RISE = 1'b0,
    REQ_FALL = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [STAMP_W-1:0] stamp;
  } cpm_in_t;

  typedef struct packed {
    logic [STAMP_W-1:0] period_ticks;
    logic [STAMP_W-1:0] on_ticks;
    logic [FREQ_W-1:0]  freq_hz;
    logic [PULSE_W-1:0] pulse_ns;
  } cpm_out_t;

  typedef struct packed {
    logic capture;
    logic take_first_rise;
    logic take_first_fall;
    logic take_second_rise;
    logic start_div;
    logic div_step;
    logic load_out;
  } cpm_cmd_t;

  typedef struct packed {
    logic window_ok;
    logic out_free;
  } cpm_status_t;

endpackage

// ===== rtl/cpm_ctrl.sv =====
// Sequencer of the capture period pulse meter: pending flags, phase and divider count.
module cpm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_type_i,
  output logic                 in_stall_o,
  input  cpm_pkg::cpm_status_t status_i,
  output cpm_pkg::cpm_cmd_t    cmd_o
);
  import cpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DIV,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_RISE1,
    PH_FALL1,
    PH_RISE2,
    PH_FALL2
  } phase_e;

  state_e               state_q;
  phase_e               phase_q;
  logic                 rise_pend_q;
  logic                 fall_pend_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_IDLE: ;
      S_STEP: begin
        priority if (phase_q == PH_RISE1 && rise_pend_q) begin
          cmd_o.take_first_rise = 1'b1;
        end else if (phase_q == PH_FALL1 && fall_pend_q) begin
          cmd_o.take_first_fall = 1'b1;
        end else if (phase_q == PH_RISE2 && rise_pend_q) begin
          cmd_o.take_second_rise = 1'b1;
        end else if (phase_q == PH_FALL2 && fall_pend_q) begin
          cmd_o.start_div = status_i.window_ok;
        end else begin
        end
      end
      S_DIV:  cmd_o.div_step = 1'b1;
      S_EMIT: cmd_o.load_out = status_i.out_free;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_RISE1;
      rise_pend_q <= 1'b0;
      fall_pend_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            if (in_req_type_i == REQ_FALL) begin
              fall_pend_q <= 1'b1;
            end else begin
              rise_pend_q <= 1'b1;
            end
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          // one consumption per cycle, until nothing pending matches the phase or the window closes
          priority if (phase_q == PH_RISE1 && rise_pend_q) begin
            rise_pend_q <= 1'b0;
            phase_q     <= PH_FALL1;
          end else if (phase_q == PH_FALL1 && fall_pend_q) begin
            fall_pend_q <= 1'b0;
            phase_q     <= PH_RISE2;
          end else if (phase_q == PH_RISE2 && rise_pend_q) begin
            rise_pend_q <= 1'b0;
            phase_q     <= PH_FALL2;
          end else if (phase_q == PH_FALL2 && fall_pend_q) begin
            rise_pend_q <= 1'b0;
            fall_pend_q <= 1'b0;
            phase_q     <= PH_RISE1;
            cnt_q       <= '0;
            state_q     <= status_i.window_ok ? S_DIV : S_IDLE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(DIV_LAST)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/cpm_dp.sv =====
// Datapath of the capture period pulse meter: stamps, divider, pulse scaling, output register.
module cpm_dp #(
  parameter int StampBits = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [cpm_pkg::FREQ_W-1:0]          cfg_wr_data_i,
  input  cpm_pkg::cpm_in_t                    in_item_i,
  input  cpm_pkg::cpm_cmd_t                   cmd_i,
  output cpm_pkg::cpm_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cpm_pkg::cpm_out_t                   out_item_o
);
  import cpm_pkg::*;

  logic [FREQ_W-1:0]    freq_num_q;
  logic [StampBits-1:0] latest_rise_q, latest_fall_q;
  logic [StampBits-1:0] first_rise_q, first_fall_q, second_rise_q;
  logic [StampBits-1:0] period_q, on_q, rem_q;
  logic [FREQ_W-1:0]    quo_q;
  logic [PROD_W-1:0]    prod_q;
  logic [MUL_W-1:0]     mul_q;
  cpm_out_t             out_q;
  logic                 out_valid_q;

  logic [StampBits-1:0] stamp;
  logic [StampBits-1:0] period_d, on_d, rem_d;
  logic [StampBits:0]   trial, trial_diff;
  logic                 fits;
  logic [PULSE_W-1:0]   pulse_est, pulse_ns;
  logic [PROD_W-1:0]    pulse_back, pulse_rem;

  assign stamp    = in_item_i.stamp[StampBits-1:0];
  assign period_d = second_rise_q - first_rise_q;
  assign on_d     = (first_fall_q > first_rise_q) ? (first_fall_q - first_rise_q)
                                                  : (first_rise_q - first_fall_q);

  // restoring divide, one quotient bit per step
  assign trial      = {rem_q, quo_q[FREQ_W-1]};
  assign trial_diff = trial - {1'b0, period_q};
  assign fits       = (trial >= {1'b0, period_q});
  assign rem_d      = fits ? trial_diff[StampBits-1:0] : trial[StampBits-1:0];

  // reciprocal estimate is exact or one low; fix with one compare
  assign pulse_est  = mul_q[RECIP_SHIFT +: PULSE_W];
  assign pulse_back = PROD_W'({pulse_est, 4'b0000}) + PROD_W'({pulse_est, 1'b0});
  assign pulse_rem  = prod_q - pulse_back;
  assign pulse_ns   = (pulse_rem >= PROD_W'(PULSE_DIV)) ? pulse_est + PULSE_W'(1) : pulse_est;

  assign status_o.window_ok = (second_rise_q > first_rise_q) && (latest_fall_q > first_fall_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_num_q  <= FREQ_NUM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        freq_num_q <= cfg_wr_data_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (in_item_i.req_type == REQ_FALL) begin
        latest_fall_q <= stamp;
      end else begin
        latest_rise_q <= stamp;
      end
    end
    if (cmd_i.take_first_rise) begin
      first_rise_q <= latest_rise_q;
    end
    if (cmd_i.take_first_fall) begin
      first_fall_q <= latest_fall_q;
    end
    if (cmd_i.take_second_rise) begin
      second_rise_q <= latest_rise_q;
    end
    if (cmd_i.start_div) begin
      period_q <= period_d;
      on_q     <= on_d;
      prod_q   <= PROD_W'(on_d) * PROD_W'(PULSE_MUL);
      quo_q    <= freq_num_q;
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FREQ_W-2:0], fits};
    end
    mul_q <= MUL_W'(prod_q) * MUL_W'(RECIP_MUL);
    if (cmd_i.load_out) begin
      out_q.period_ticks <= STAMP_W'(period_q);
      out_q.on_ticks     <= STAMP_W'(on_q);
      out_q.freq_hz      <= quo_q;
      out_q.pulse_ns     <= pulse_ns;
    end
  end

endmodule

// ===== rtl/capture_period_pulse_meter.sv =====
// Top level of the capture period pulse meter: sequencer, datapath and checks.
// An item that closes a window passes through its phase steps, 32 divider steps (one quotient
// bit each, radix 2) and the output load, in that order, before its result appears.
// Input stall: an item that gives no result holds the input stalled while its phase steps run; one that
// gives a result holds it until the result is loaded, longer while the output stalls.
// Reset: state, phase, pending flags, divider count and output valid clear; the numerator reloads 1152000000.
module capture_period_pulse_meter #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [cpm_pkg::FREQ_W-1:0] cfg_wr_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cpm_pkg::cpm_in_t           in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cpm_pkg::cpm_out_t          out_item_o
);
  import cpm_pkg::*;

  // stamps keep only the low counter bits, and never more than the field carries
  localparam int StampBits = (COUNTER_BITS < STAMP_W) ? COUNTER_BITS : STAMP_W;

  cpm_cmd_t    cmd;
  cpm_status_t status;

  // Sequencer: walks rising, falling, rising, falling one step per cycle while a pending edge
  // matches, then, for a valid window, counts the divider steps and waits for the output register.
  cpm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_item_i.req_type),
    .in_stall_o    (in_stall_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Datapath: stamp registers, window check, frequency divider,
  // pulse width scaling and the result register that decouples the output.
  cpm_dp #(
    .StampBits (StampBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_item_i     (in_item_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

`ifndef ASSERT_OFF
  // an accepted item keeps the sequencer busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // a result only comes from a window whose second rising stamp is later
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.period_ticks != '0)
    else $error("result with zero period");

  // a new result is loaded only at the end of busy work
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the sequencer was idle");
`endif

endmodule
